[rtl/mmf_pkg.sv]
`default_nettype none

package mmf_pkg;

  // Field widths.
  localparam int SampleW  = 16;
  localparam int FadeW    = 10;
  localparam int GainFrac = 15;

  // Gain numerator is the ramp multiplier times the Q15 full scale.
  localparam int DivW    = FadeW + GainFrac;
  localparam int DivCntW = $clog2(DivW);

  // Action codes of an input item.
  localparam logic [1:0] ActProcess = 2'd0;
  localparam logic [1:0] ActFadeIn  = 2'd1;
  localparam logic [1:0] ActFadeOut = 2'd2;

  // Channel selection modes. Any other code averages.
  localparam logic [1:0] ModeLeft  = 2'd0;
  localparam logic [1:0] ModeRight = 2'd1;

  // Fade status codes of a result item.
  localparam logic [1:0] StatNone    = 2'd0;
  localparam logic [1:0] StatOutDone = 2'd1;
  localparam logic [1:0] StatInDone  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic RegChannelMode = 1'b0;
  localparam logic RegFadeLength  = 1'b1;

  // Register reset values.
  localparam logic [1:0]       ChannelModeReset = 2'd2;
  localparam logic [FadeW-1:0] FadeLengthReset  = 10'd128;

  // Longest ramp a fade command may load.
  localparam int FadeMax = 1023;

  // Filter and gain constants.
  localparam logic signed [16:0]    DcAlpha = 17'sd32512;
  localparam logic [GainFrac-1:0]   GainMax = 15'd32767;
  localparam int                    LpShift = 3;

  // One input item.
  typedef struct packed {
    logic [1:0]                action;
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
    logic                      stereo;
    logic                      frame_end;
  } mmf_in_t;

  // One result item.
  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic [1:0]                fade_status;
    logic                      frame_last;
  } mmf_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_sample;
    logic fade_in;
    logic fade_out;
    logic hp_step;
    logic lp_step;
    logic div_step;
    logic gain_step;
    logic finish;
  } mmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fade_active;
    logic len_zero;
    logic out_free;
  } mmf_stat_t;

endpackage

`default_nettype wire

[rtl/mmf_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per step, used for the fade gain.
module mmf_div import mmf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            load_i,
  input  wire logic            step_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [FadeW-1:0] divisor_i,
  output logic [DivW-1:0]      quotient_o
);

  logic [FadeW-1:0] rem_q, rem_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [FadeW-1:0] den_q;
  logic [FadeW:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? FadeW'(trial - {1'b0, den_q}) : trial[FadeW-1:0];
    quo_d = {quo_q[DivW-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[rtl/mmf_ctrl.sv]
`default_nettype none

// Sequencer for one sample: filter steps, gain division and gain while a fade is active, result.
module mmf_ctrl import mmf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] action_i,
  input  wire mmf_stat_t  stat_i,
  output logic            in_ready_o,
  output mmf_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HP,
    S_LP,
    S_DIV,
    S_GAIN,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [DivCntW-1:0]   cnt_q;

  // Command decode from the current state.
  always_comb begin
    cmd_o             = '0;
    in_ready_o        = state_q == S_IDLE;
    cmd_o.load_sample = (state_q == S_IDLE) && in_valid_i && (action_i == ActProcess);
    cmd_o.fade_in     = (state_q == S_IDLE) && in_valid_i && (action_i == ActFadeIn);
    cmd_o.fade_out    = (state_q == S_IDLE) && in_valid_i && (action_i == ActFadeOut);
    cmd_o.hp_step     = state_q == S_HP;
    cmd_o.lp_step     = state_q == S_LP;
    cmd_o.div_step    = state_q == S_DIV;
    cmd_o.gain_step   = state_q == S_GAIN;
    cmd_o.finish      = (state_q == S_DONE) && stat_i.out_free;
  end

  // State and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && (action_i == ActProcess)) begin
            state_q <= S_HP;
          end
        end
        S_HP: begin
          state_q <= S_LP;
        end
        S_LP: begin
          cnt_q <= '0;
          priority if (stat_i.fade_active && !stat_i.len_zero) begin
            state_q <= S_DIV;
          end else if (stat_i.fade_active) begin
            state_q <= S_GAIN;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntW'(DivW - 1)) begin
            state_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/mmf_dp.sv]
`default_nettype none

// Sample datapath: channel mix, DC blocker, low-pass, fade gain and result register.
module mmf_dp import mmf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mmf_in_t          in_data_i,
  input  wire logic [1:0]       channel_mode_i,
  input  wire logic [FadeW-1:0] fade_length_i,
  input  wire mmf_cmd_t         cmd_i,
  output mmf_stat_t             stat_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output mmf_out_t              out_data_o
);

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end
    return v[SampleW-1:0];
  endfunction

  // Filter and fade state.
  logic signed [SampleW-1:0] dci_q, dci_d;
  logic signed [31:0]        dco_q, dco_d;
  logic signed [31:0]        lp_q, lp_d;
  logic                      fin_q, fin_d;
  logic                      fout_q, fout_d;
  logic [FadeW-1:0]          left_q, left_d;
  logic                      zuf_q, zuf_d;
  logic                      out_valid_q;

  // Per-sample working registers.
  logic signed [SampleW-1:0] x_q;
  logic signed [47:0]        prod_q;
  logic                      fe_q;
  logic signed [32:0]        prod2_q;
  mmf_out_t                  out_q, out_d;

  logic signed [SampleW-1:0] mixed;
  logic signed [SampleW:0]   pair_sum;
  logic signed [SampleW:0]   pair_avg;
  logic signed [47:0]        alpha_prod;
  logic signed [31:0]        hp_sum;
  logic signed [32:0]        lp_diff;
  logic signed [32:0]        lp_step;
  logic signed [SampleW-1:0] y_filt;
  logic                      fade_active;
  logic [FadeW-1:0]          ramp_pos;
  logic [FadeW-1:0]          ramp_mult;
  logic [DivW-1:0]           gain_num;
  logic [DivW-1:0]           quotient;
  logic [SampleW-1:0]        gain;
  logic signed [32:0]        gain_prod;
  logic [FadeW-1:0]          fade_len_cap;

  // Channel selection; the average truncates toward zero.
  always_comb begin
    pair_sum = (SampleW+1)'(in_data_i.left_sample) + (SampleW+1)'(in_data_i.right_sample);
    pair_avg = (pair_sum + (SampleW+1)'({1'b0, pair_sum[SampleW]})) >>> 1;
    priority if (!in_data_i.stereo || (channel_mode_i == ModeLeft)) begin
      mixed = in_data_i.left_sample;
    end else if (channel_mode_i == ModeRight) begin
      mixed = in_data_i.right_sample;
    end else begin
      mixed = pair_avg[SampleW-1:0];
    end
  end

  // DC blocker feedback product, then the two filter updates.
  assign alpha_prod = dco_q * DcAlpha;
  assign hp_sum     = 32'(x_q) - 32'(dci_q) + prod_q[46:15];
  assign lp_diff    = 33'(dco_q) - 33'(lp_q);
  assign lp_step    = lp_diff >>> LpShift;
  assign y_filt     = sat16(48'(lp_q));

  always_comb begin
    dci_d = dci_q;
    dco_d = dco_q;
    lp_d  = lp_q;
    if (cmd_i.hp_step) begin
      dci_d = x_q;
      dco_d = hp_sum;
    end
    if (cmd_i.lp_step) begin
      lp_d = lp_q + lp_step[31:0];
    end
  end

  // Ramp position and gain numerator; the position saturates to zero when the
  // remaining count exceeds the current length.
  assign fade_active = (fin_q || fout_q) && (left_q != '0);
  assign ramp_pos    = (left_q > fade_length_i) ? '0 : fade_length_i - left_q + 1'b1;
  assign ramp_mult   = fout_q ? fade_length_i - ramp_pos : ramp_pos;
  assign gain_num    = {ramp_mult, {GainFrac{1'b0}}} - DivW'(ramp_mult);

  mmf_div u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.hp_step),
    .step_i     (cmd_i.div_step),
    .dividend_i (gain_num),
    .divisor_i  (fade_length_i),
    .quotient_o (quotient)
  );

  // A zero length gives a fixed gain without division.
  always_comb begin
    if (fade_length_i == '0) begin
      gain = fin_q ? '0 : SampleW'(GainMax);
    end else begin
      gain = quotient[SampleW-1:0];
    end
  end

  assign gain_prod    = 33'(y_filt) * 33'($signed({1'b0, gain}));
  assign fade_len_cap = (32'(fade_length_i) > FadeMax) ? FadeW'(FadeMax) : fade_length_i;

  // Fade bookkeeping and the result for the finished sample.
  always_comb begin
    fin_d  = fin_q;
    fout_d = fout_q;
    left_d = left_q;
    zuf_d  = zuf_q;
    out_d  = out_q;
    if (cmd_i.fade_in || cmd_i.fade_out) begin
      left_d = fade_len_cap;
      fin_d  = cmd_i.fade_in;
      fout_d = cmd_i.fade_out;
    end
    if (cmd_i.finish) begin
      out_d.fade_status = StatNone;
      out_d.frame_last  = fe_q;
      out_d.sample_out  = y_filt;
      if (fade_active) begin
        out_d.sample_out = sat16(48'(prod2_q >>> GainFrac));
        left_d           = left_q - 1'b1;
        if (left_q == FadeW'(1)) begin
          out_d.fade_status = fout_q ? StatOutDone : StatInDone;
          if (fout_q && !fe_q) begin
            zuf_d = 1'b1;
          end
          fin_d  = 1'b0;
          fout_d = 1'b0;
        end
      end
      if (zuf_q) begin
        out_d.sample_out = '0;
      end
      if (fe_q) begin
        zuf_d = 1'b0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dci_q       <= '0;
      dco_q       <= '0;
      lp_q        <= '0;
      fin_q       <= 1'b0;
      fout_q      <= 1'b0;
      left_q      <= '0;
      zuf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      dci_q  <= dci_d;
      dco_q  <= dco_d;
      lp_q   <= lp_d;
      fin_q  <= fin_d;
      fout_q <= fout_d;
      left_q <= left_d;
      zuf_q  <= zuf_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      x_q    <= mixed;
      fe_q   <= in_data_i.frame_end;
      prod_q <= alpha_prod;
    end
    if (cmd_i.gain_step) begin
      prod2_q <= gain_prod;
    end
    out_q <= out_d;
  end

  assign stat_o.fade_active = fade_active;
  assign stat_o.len_zero    = fade_length_i == '0;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

`ifndef ASSERT_OFF
  // Only one fade direction is ever active.
  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fin_q && fout_q))
    else $error("both fade directions active");

  // A result appears only after the controller finishes a sample.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result without a finished sample");

  // A finished sample never overwrites a result that was not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

[rtl/mic_mix_filter_fade_core.sv]
`default_nettype none

// Microphone front end: each process transfer yields one mono sample after
// channel selection, a DC blocker and a one-pole low-pass, with an optional
// linear fade; fade commands yield no result. While a fade ramps, the gain
// comes from the 25-step serial divider; a fade whose length is now zero
// skips the division. One sample is worked on at a time, and a result
// register lets the next input transfer be taken while the previous result
// still waits. Registers: channel mode at byte address 0, fade length at
// byte address 4; configure only while the block is idle.
module mic_mix_filter_fade_core import mmf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire mmf_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output mmf_out_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0]       channel_mode_q;
  logic [FadeW-1:0] fade_length_q;
  mmf_cmd_t         cmd;
  mmf_stat_t        stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_mode_q <= ChannelModeReset;
      fade_length_q  <= FadeLengthReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegChannelMode: channel_mode_q <= pwdata[1:0];
        RegFadeLength:  fade_length_q  <= pwdata[FadeW-1:0];
        default:        channel_mode_q <= channel_mode_q;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[2])
      RegChannelMode: prdata = 32'(channel_mode_q);
      RegFadeLength:  prdata = 32'(fade_length_q);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  mmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_data_i.action),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  mmf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_data_i      (in_data_i),
    .channel_mode_i (channel_mode_q),
    .fade_length_i  (fade_length_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_data_o     (out_data_o)
  );

endmodule

`default_nettype wire

[dv/mic_mix_filter_fade_core_tb.sv]
`timescale 1ns / 100ps

module mic_mix_filter_fade_core_tb;
  import mmf_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] ActUnused   = 2'd3;
  localparam logic [1:0] ModeAverage = 2'd2;
  localparam logic [1:0] ModeSpare   = 2'd3;

  // DC blocker pole in Q15, and the longest stretch without any transfer.
  localparam longint HpPole      = 32512;
  localparam int     QuietLimit  = 2000;
  localparam int     SettleTicks = 32;
  localparam int     PhaseItems  = 105;
  localparam int     PrintCap    = 60;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  // One line of the directed stimulus.
  typedef struct {
    row_kind_e kind;
    logic      reg_idx;
    int        reg_val;
    mmf_in_t   item;
    bit        typed;
    mmf_out_t  want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mmf_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  mmf_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the registers and of the filter and fade state.
  logic [1:0] sel_mode = ModeAverage;
  int         ramp_len = int'(FadeLengthReset);
  int         hp_prev_in = 0;
  int         hp_prev_out = 0;
  int         lp_acc = 0;
  bit         ramp_in = 1'b0;
  bit         ramp_out = 1'b0;
  int         ramp_left = 0;
  bit         mute_rest = 1'b0;

  mmf_out_t   pending_samples[$];
  stim_row_t  directed_rows[$];
  int         n_bad = 0;
  int         quiet_cycles = 0;
  int         sink_hold = 0;
  bit         no_idle = 1'b0;

  mic_mix_filter_fade_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advances the shadow state by one input transfer; returns 1 when the
  // transfer yields a sample.
  function automatic bit front_end_step(input mmf_in_t it, output mmf_out_t res);
    longint l, r, mix, hp, y, ramp_pos, gain;
    bit mute_now;
    logic [1:0] status;
    res = '0;
    status = StatNone;
    if (it.action == ActFadeIn || it.action == ActFadeOut) begin
      ramp_left = (ramp_len > FadeMax) ? FadeMax : ramp_len;
      ramp_in = (it.action == ActFadeIn);
      ramp_out = !ramp_in;
      return 1'b0;
    end
    if (it.action != ActProcess) return 1'b0;

    // Channel selection; the average truncates toward zero.
    l = longint'($signed(it.left_sample));
    r = longint'($signed(it.right_sample));
    if (!it.stereo || sel_mode == ModeLeft) mix = l;
    else if (sel_mode == ModeRight) mix = r;
    else mix = (l + r) / 2;

    // DC blocker, then the one-pole low-pass, both with 32-bit state.
    hp = mix - longint'(hp_prev_in) + ((HpPole * longint'(hp_prev_out)) >>> 15);
    hp_prev_in = int'(mix);
    hp_prev_out = int'(hp);
    lp_acc = int'(longint'(lp_acc) + ((longint'(hp_prev_out) - longint'(lp_acc)) >>> 3));
    y = clip16(longint'(lp_acc));

    // Linear fade gain for ramp position k of L.
    mute_now = mute_rest;
    if ((ramp_in || ramp_out) && ramp_left != 0) begin
      ramp_pos = (ramp_left > ramp_len) ? 0 : longint'(ramp_len - ramp_left + 1);
      if (ramp_len == 0) gain = ramp_in ? 0 : 32767;
      else if (ramp_in) gain = (ramp_pos * 32767) / ramp_len;
      else gain = ((ramp_len - ramp_pos) * 32767) / ramp_len;
      y = clip16((y * gain) >>> 15);
      ramp_left = ramp_left - 1;
      if (ramp_left == 0) begin
        status = ramp_out ? StatOutDone : StatInDone;
        if (ramp_out && !it.frame_end) mute_rest = 1'b1;
        ramp_in = 1'b0;
        ramp_out = 1'b0;
      end
    end
    if (mute_now) y = 0;
    if (it.frame_end) mute_rest = 1'b0;

    res.sample_out = y[15:0];
    res.fade_status = status;
    res.frame_last = it.frame_end;
    return 1'b1;
  endfunction

  function automatic mmf_in_t make_item(input logic [1:0] act, input int l, input int r,
                                        input bit st, input bit fe);
    mmf_in_t it;
    it.action = act;
    it.left_sample = l[15:0];
    it.right_sample = r[15:0];
    it.stereo = st;
    it.frame_end = fe;
    return it;
  endfunction

  function automatic stim_row_t item_row(input logic [1:0] act, input int l, input int r,
                                         input bit st, input bit fe);
    stim_row_t row;
    row.kind = RowItem;
    row.reg_idx = RegChannelMode;
    row.reg_val = 0;
    row.item = make_item(act, l, r, st, fe);
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input int l, input bit fe, input logic [1:0] stat);
    stim_row_t row;
    row = item_row(ActProcess, l, 0, 1'b0, fe);
    row.typed = 1'b1;
    row.want.sample_out = '0;
    row.want.fade_status = stat;
    row.want.frame_last = fe;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic idx, input int val);
    stim_row_t row;
    row = item_row(ActProcess, 0, 0, 1'b0, 1'b0);
    row.kind = RowReg;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic logic [15:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h7fff;
    if (pick == 1) return 16'h8000;
    if (pick == 2) return 16'($urandom_range(0, 200) - 100);
    return 16'($urandom());
  endfunction

  // Mostly samples with random content, a few fade commands and unused codes.
  function automatic mmf_in_t rand_item();
    mmf_in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) it.action = ActFadeIn;
    else if (pick < 6) it.action = ActFadeOut;
    else if (pick < 8) it.action = ActUnused;
    else it.action = ActProcess;
    it.left_sample = rand_sample();
    it.right_sample = rand_sample();
    it.stereo = 1'($urandom_range(0, 1));
    it.frame_end = ($urandom_range(0, 11) == 0);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_bad < PrintCap) $display("mismatch on %s: got %0d, want %0d", what, got, want);
    n_bad++;
  endtask

  // Presents one item, waits for its transfer and records what it should yield.
  task automatic transfer_item(input mmf_in_t it, input bit typed, input mmf_out_t want);
    int gap;
    mmf_out_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    if (front_end_step(it, predicted)) pending_samples.push_back(typed ? want : predicted);
  endtask

  // Stops the input side and lets every outstanding sample come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegChannelMode) sel_mode = val[1:0];
    else ramp_len = int'(val[9:0]);
  endtask

  // Result side: random stalls, and each transfer is checked in order.
  always @(posedge clk_i) begin : sink
    mmf_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected sample", int'($signed(out_data.sample_out)), 0);
      end else begin
        want = pending_samples.pop_front();
        if (out_data.sample_out !== want.sample_out)
          report_mismatch("sample_out", int'($signed(out_data.sample_out)),
                          int'($signed(want.sample_out)));
        if (out_data.fade_status !== want.fade_status)
          report_mismatch("fade_status", int'(out_data.fade_status), int'(want.fade_status));
        if (out_data.frame_last !== want.frame_last)
          report_mismatch("frame_last", int'(out_data.frame_last), int'(want.frame_last));
      end
      sink_hold = no_idle ? 0 : $urandom_range(0, 5);
    end else if (sink_hold > 0) begin
      sink_hold--;
    end
    out_ready <= (sink_hold == 0);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", QuietLimit);
      $display("mic_mix_filter_fade_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    mmf_in_t it;
    int count;
    logic [1:0] phase_mode[8];
    int phase_len[8];

    // Directed part: extremes, every action, fades of length one and zero,
    // every channel mode and a length change in the middle of a fade.
    directed_rows.push_back(typed_row(0, 1'b0, StatNone));
    directed_rows.push_back(typed_row(0, 1'b1, StatNone));
    directed_rows.push_back(item_row(ActProcess, 32767, 32767, 1'b1, 1'b0));
    directed_rows.push_back(item_row(ActProcess, -32768, -32768, 1'b1, 1'b0));
    directed_rows.push_back(item_row(ActProcess, 32767, -32768, 1'b1, 1'b0));
    directed_rows.push_back(item_row(ActProcess, -32768, 32767, 1'b0, 1'b0));
    directed_rows.push_back(item_row(ActUnused, 32767, -1, 1'b1, 1'b1));
    directed_rows.push_back(reg_row(RegFadeLength, 1));
    // Fade-out ending on the last sample of a frame: no muting follows.
    directed_rows.push_back(item_row(ActFadeOut, -1, -1, 1'b1, 1'b1));
    directed_rows.push_back(typed_row(1000, 1'b1, StatOutDone));
    // Fade-out ending inside a frame mutes up to the frame end.
    directed_rows.push_back(item_row(ActFadeOut, 0, 0, 1'b0, 1'b0));
    directed_rows.push_back(typed_row(-500, 1'b0, StatOutDone));
    directed_rows.push_back(typed_row(32767, 1'b0, StatNone));
    directed_rows.push_back(typed_row(-32768, 1'b1, StatNone));
    directed_rows.push_back(reg_row(RegChannelMode, ModeLeft));
    directed_rows.push_back(item_row(ActFadeIn, 123, 456, 1'b1, 1'b0));
    directed_rows.push_back(item_row(ActProcess, 1234, -5, 1'b1, 1'b0));
    directed_rows.push_back(reg_row(RegFadeLength, 0));
    directed_rows.push_back(item_row(ActFadeIn, 0, 0, 1'b0, 1'b0));
    directed_rows.push_back(item_row(ActProcess, 20000, -20000, 1'b1, 1'b0));
    directed_rows.push_back(reg_row(RegChannelMode, ModeRight));
    directed_rows.push_back(item_row(ActProcess, 20000, -20000, 1'b1, 1'b0));
    directed_rows.push_back(reg_row(RegChannelMode, ModeSpare));
    directed_rows.push_back(item_row(ActProcess, -3, 2, 1'b1, 1'b0));
    directed_rows.push_back(reg_row(RegFadeLength, 1023));
    directed_rows.push_back(reg_row(RegChannelMode, ModeAverage));
    directed_rows.push_back(item_row(ActFadeOut, 0, 0, 1'b0, 1'b0));
    directed_rows.push_back(item_row(ActProcess, 30000, 30000, 1'b1, 1'b0));
    // Shorter length than what is left of the ramp, then length zero.
    directed_rows.push_back(reg_row(RegFadeLength, 5));
    directed_rows.push_back(item_row(ActProcess, -30000, 10, 1'b0, 1'b0));
    directed_rows.push_back(reg_row(RegFadeLength, 0));
    directed_rows.push_back(item_row(ActProcess, 16000, 16000, 1'b1, 1'b1));

    // Random phases, each under its own register setting.
    phase_mode = '{ModeAverage, ModeLeft, ModeRight, ModeSpare,
                   ModeAverage, ModeRight, ModeLeft, ModeAverage};
    phase_len = '{128, 1, 3, 0, 1023, 16, 7, 2};
    phase_mode[6] = 2'($urandom_range(0, 3));
    phase_len[6] = $urandom_range(1, 40);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == RowReg) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        transfer_item(row.item, row.typed, row.want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      write_reg(RegChannelMode, int'(phase_mode[p]));
      write_reg(RegFadeLength, phase_len[p]);
      no_idle = (p % 3 == 2);
      count = 0;
      while (count < PhaseItems) begin
        it = rand_item();
        transfer_item(it, 1'b0, '0);
        if (it.action != ActUnused) count++;
      end
    end

    // Drain and let the block sit for a while to catch stray samples.
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("mic_mix_filter_fade_core_tb: PASS");
    end else begin
      $display("mic_mix_filter_fade_core_tb: FAIL");
    end
    $finish;
  end

endmodule
